// ----- rtl/core/two_stack_deque_defines.svh -----
// Assertion macros shared by the deque RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef TWO_STACK_DEQUE_DEFINES_SVH
`define TWO_STACK_DEQUE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked on clk_i, held off while rst_ni is low
`define TSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Same, with explicit clock and active-low reset
`define TSD_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`else
`define TSD_ASSERT(lbl, prop, msg)
`define TSD_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`endif

`endif

// ----- rtl/core/tsd_pkg.sv -----
// Package for the two-stack deque: command and status codes, field widths
// and the controller-to-datapath command struct. No dependencies.
`timescale 1ns / 1ps

package tsd_pkg;

  // Fixed field widths of the request and result
  localparam int CMD_W       = 2;
  localparam int POS_W       = 9;
  localparam int VAL_W       = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 10;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 112;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_READ       = 2'd2,
    CMD_WRITE      = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Controller strobes into the datapath
  typedef struct packed {
    logic capture;   // latch the incoming request
    logic execute;   // apply the latched request to the stacks
  } dp_cmd_t;

endpackage

// ----- rtl/core/two_stack_deque.sv -----
// Deque built from two stacks. Each request (push front, push back, read at
// index, write at index) gives one result with status, read value, element
// count, empty flag and the front and back elements after the request. A
// request is taken, then applied in the next cycle with a write to at most
// one stack memory and a registered read of both; the result is then held
// until taken, and no new request is taken before that.
// The stack memories need no clearing after reset; the block is ready as
// soon as reset is released. Depends on tsd_pkg, tsd_ctrl, tsd_datapath.
`timescale 1ns / 1ps

module two_stack_deque #(
  parameter int STACK_DEPTH = 256,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request: cmd [1:0], position [10:2], value [42:11], zero fill above
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [tsd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // result: read_value [31:0], status [33:32], element_count [43:34],
  // is_empty [44], front_value [76:45], back_value [108:77], zero fill above
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [tsd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import tsd_pkg::*;

  dp_cmd_t                  dp_cmd;
  logic signed [VAL_W-1:0]  read_value, front_value, back_value;
  logic [STATUS_W-1:0]      status;
  logic [COUNT_W-1:0]       element_count;
  logic                     is_empty;

  tsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .dp_cmd_o    (dp_cmd)
  );

  tsd_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .dp_cmd_i        (dp_cmd),
    .cmd_i           (s_axis_tdata[CMD_W-1:0]),
    .position_i      (s_axis_tdata[CMD_W+POS_W-1:CMD_W]),
    .value_i         (s_axis_tdata[CMD_W+POS_W+VAL_W-1:CMD_W+POS_W]),
    .read_value_o    (read_value),
    .status_o        (status),
    .element_count_o (element_count),
    .is_empty_o      (is_empty),
    .front_value_o   (front_value),
    .back_value_o    (back_value)
  );

  // Pack the result fields
  assign m_axis_tdata = {3'b000, back_value, front_value, is_empty, element_count,
                         status, read_value};

endmodule

// ----- rtl/core/tsd_ctrl.sv -----
// Handshake controller of the two-stack deque: capture, execute, respond.
// Depends on tsd_pkg and two_stack_deque_defines.svh.
`timescale 1ns / 1ps
`include "two_stack_deque_defines.svh"

module tsd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tsd_pkg::dp_cmd_t dp_cmd_o
);
  import tsd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Handshake and datapath strobes
  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = (state_q == S_RESP);
  assign dp_cmd_o.capture = in_valid_i && in_ready_o;
  assign dp_cmd_o.execute = (state_q == S_EXEC);

  `TSD_ASSERT(a_no_overlap, !(in_ready_o && out_valid_o), "request taken while result pending")
  `TSD_ASSERT(a_cap_then_exec, dp_cmd_o.capture |=> dp_cmd_o.execute,
              "captured request not executed")
  `TSD_ASSERT(a_exec_then_resp, dp_cmd_o.execute |=> out_valid_o,
              "executed request gave no result")

endmodule

// ----- rtl/core/tsd_datapath.sv -----
// Datapath of the two-stack deque: two stack memories, counts, shadow
// copies of the stack ends and the result fields. Depends on tsd_pkg.
`timescale 1ns / 1ps
`include "two_stack_deque_defines.svh"

module tsd_datapath #(
  parameter int STACK_DEPTH = 256,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tsd_pkg::dp_cmd_t                dp_cmd_i,
  input  logic [tsd_pkg::CMD_W-1:0]       cmd_i,
  input  logic [tsd_pkg::POS_W-1:0]       position_i,
  input  logic signed [tsd_pkg::VAL_W-1:0] value_i,
  output logic signed [tsd_pkg::VAL_W-1:0] read_value_o,
  output logic [tsd_pkg::STATUS_W-1:0]    status_o,
  output logic [tsd_pkg::COUNT_W-1:0]     element_count_o,
  output logic                            is_empty_o,
  output logic signed [tsd_pkg::VAL_W-1:0] front_value_o,
  output logic signed [tsd_pkg::VAL_W-1:0] back_value_o
);
  import tsd_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int PW = (SW > POS_W) ? SW : POS_W;

  // Latched request
  cmd_e                  cmd_q;
  logic [POS_W-1:0]      pos_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [DATA_WIDTH-1:0] val_in;

  // Stack state
  logic [CW-1:0]         fcnt_q, bcnt_q;
  logic [DATA_WIDTH-1:0] ftop_q, fbot_q, btop_q, bbot_q;
  logic [DATA_WIDTH-1:0] front_mem [STACK_DEPTH];
  logic [DATA_WIDTH-1:0] back_mem  [STACK_DEPTH];

  // Result registers
  logic [DATA_WIDTH-1:0] front_rd_q, back_rd_q;
  logic                  rd_front_q, rd_ok_q;
  status_e               status_q;

  // Request decode
  logic [PW-1:0] pos_ext, fcnt_ext, size_ext, faddr_ext, baddr_ext;
  logic [AW-1:0] faddr, baddr, fwaddr, bwaddr;
  logic          is_pf, is_pb, is_rd, is_wr;
  logic          front_full, back_full, in_range, in_front;
  logic          push_f_ok, push_b_ok, wr_f, wr_b, fwe, bwe;

  // Input element: sign-extend or cut 32 bits to DATA_WIDTH
  generate
    if (DATA_WIDTH > VAL_W) begin : g_in_ext
      assign val_in = {{(DATA_WIDTH-VAL_W){value_i[VAL_W-1]}}, value_i};
    end else begin : g_in_cut
      assign val_in = value_i[DATA_WIDTH-1:0];
    end
  endgenerate

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.capture) begin
      cmd_q <= cmd_e'(cmd_i);
      pos_q <= position_i;
      val_q <= val_in;
    end
  end

  // Index decode against the current counts
  always_comb begin
    is_pf      = (cmd_q == CMD_PUSH_FRONT);
    is_pb      = (cmd_q == CMD_PUSH_BACK);
    is_rd      = (cmd_q == CMD_READ);
    is_wr      = (cmd_q == CMD_WRITE);
    pos_ext    = PW'(pos_q);
    fcnt_ext   = PW'(fcnt_q);
    size_ext   = PW'(fcnt_q) + PW'(bcnt_q);
    faddr_ext  = fcnt_ext - pos_ext - PW'(1);
    baddr_ext  = pos_ext - fcnt_ext;
    faddr      = faddr_ext[AW-1:0];
    baddr      = baddr_ext[AW-1:0];
    front_full = (fcnt_q == CW'(STACK_DEPTH));
    back_full  = (bcnt_q == CW'(STACK_DEPTH));
    in_range   = (pos_ext < size_ext);
    in_front   = (pos_ext < fcnt_ext);
    push_f_ok  = is_pf && !front_full;
    push_b_ok  = is_pb && !back_full;
    wr_f       = is_wr && in_range && in_front;
    wr_b       = is_wr && in_range && !in_front;
    fwe        = dp_cmd_i.execute && (push_f_ok || wr_f);
    bwe        = dp_cmd_i.execute && (push_b_ok || wr_b);
    fwaddr     = is_pf ? fcnt_q[AW-1:0] : faddr;
    bwaddr     = is_pb ? bcnt_q[AW-1:0] : baddr;
  end

  // Stack memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (fwe) front_mem[fwaddr] <= val_q;
    if (dp_cmd_i.execute) front_rd_q <= front_mem[faddr];
  end

  always_ff @(posedge clk_i) begin
    if (bwe) back_mem[bwaddr] <= val_q;
    if (dp_cmd_i.execute) back_rd_q <= back_mem[baddr];
  end

  // Counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcnt_q <= '0;
      bcnt_q <= '0;
    end else if (dp_cmd_i.execute) begin
      if (push_f_ok) fcnt_q <= fcnt_q + CW'(1);
      if (push_b_ok) bcnt_q <= bcnt_q + CW'(1);
    end
  end

  // Shadow copies of both ends of both stacks
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.execute) begin
      if (push_f_ok || (wr_f && pos_ext == '0)) ftop_q <= val_q;
      if ((push_f_ok && fcnt_q == '0) || (wr_f && pos_ext == fcnt_ext - PW'(1)))
        fbot_q <= val_q;
      if (push_b_ok || (wr_b && pos_ext == size_ext - PW'(1))) btop_q <= val_q;
      if ((push_b_ok && bcnt_q == '0) || (wr_b && pos_ext == fcnt_ext))
        bbot_q <= val_q;
    end
  end

  // Status and read select
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.execute) begin
      rd_front_q <= in_front;
      rd_ok_q    <= is_rd && in_range;
      if ((is_pf && front_full) || (is_pb && back_full)) begin
        status_q <= ST_FULL;
      end else if ((is_rd || is_wr) && !in_range) begin
        status_q <= ST_RANGE;
      end else begin
        status_q <= ST_OK;
      end
    end
  end

  // Result fields
  logic [DATA_WIDTH-1:0] rd_el, fv_el, bv_el;
  logic [VAL_W-1:0]      rd_out, fv_out, bv_out;
  logic [SW-1:0]         size_now;

  always_comb begin
    rd_el    = rd_front_q ? front_rd_q : back_rd_q;
    fv_el    = (fcnt_q != '0) ? ftop_q : bbot_q;
    bv_el    = (bcnt_q != '0) ? btop_q : fbot_q;
    size_now = SW'(fcnt_q) + SW'(bcnt_q);
  end

  // Output elements: sign-extend or cut DATA_WIDTH to 32 bits
  generate
    if (DATA_WIDTH >= VAL_W) begin : g_out_cut
      assign rd_out = rd_el[VAL_W-1:0];
      assign fv_out = fv_el[VAL_W-1:0];
      assign bv_out = bv_el[VAL_W-1:0];
    end else begin : g_out_ext
      assign rd_out = {{(VAL_W-DATA_WIDTH){rd_el[DATA_WIDTH-1]}}, rd_el};
      assign fv_out = {{(VAL_W-DATA_WIDTH){fv_el[DATA_WIDTH-1]}}, fv_el};
      assign bv_out = {{(VAL_W-DATA_WIDTH){bv_el[DATA_WIDTH-1]}}, bv_el};
    end
  endgenerate

  generate
    if (SW >= COUNT_W) begin : g_cnt_cut
      assign element_count_o = size_now[COUNT_W-1:0];
    end else begin : g_cnt_ext
      assign element_count_o = {{(COUNT_W-SW){1'b0}}, size_now};
    end
  endgenerate

  assign is_empty_o    = (size_now == '0);
  assign status_o      = status_q;
  assign read_value_o  = rd_ok_q ? $signed(rd_out) : '0;
  assign front_value_o = is_empty_o ? '0 : $signed(fv_out);
  assign back_value_o  = is_empty_o ? '0 : $signed(bv_out);

  `TSD_ASSERT_CLK(a_fcnt_bound, clk_i, rst_ni, fcnt_q <= CW'(STACK_DEPTH),
                  "front count beyond depth")
  `TSD_ASSERT_CLK(a_full_drop, clk_i, rst_ni,
                  (dp_cmd_i.execute && is_pf && front_full) |=> $stable(fcnt_q),
                  "push into full front stack changed its count")
  `TSD_ASSERT_CLK(a_idle_counts, clk_i, rst_ni,
                  !dp_cmd_i.execute |=> ($stable(fcnt_q) && $stable(bcnt_q)),
                  "counts moved without a request")

endmodule
